@@ sv/wcc_pkg.sv @@
// wcc_pkg: shared constants, weight table and control struct for the
// weight combination counter
// no dependencies
package wcc_pkg;

    // fixed field widths on the stream ports
    localparam int TARGET_W    = 16;
    localparam int OUT_COUNT_W = 32;

    // weight set
    localparam int NUM_WEIGHTS = 10;
    localparam int WIDX_W      = 4;
    localparam int WEIGHT_W    = 16;

    // weight for a given index, zero past the end of the set
    function automatic logic [WEIGHT_W-1:0] weight_of(input logic [WIDX_W-1:0] idx);
        logic [WEIGHT_W-1:0] w;
        case (idx)
            4'd0: w = 16'd100;
            4'd1: w = 16'd200;
            4'd2: w = 16'd300;
            4'd3: w = 16'd500;
            4'd4: w = 16'd1000;
            4'd5: w = 16'd1200;
            4'd6: w = 16'd1400;
            4'd7: w = 16'd1500;
            4'd8: w = 16'd2000;
            4'd9: w = 16'd3000;
            default: w = '0;
        endcase
        return w;
    endfunction

    // operation requested from the count table for one cycle
    typedef struct packed {
        logic clr;      // write a clear value at address a
        logic clr_one;  // clear value is one rather than zero
        logic upd;      // read a and b, add, write back to a next cycle
        logic rd;       // plain read at address a
    } tbl_op_t;

endpackage

@@ sv/wcc_count_table.sv @@
// wcc_count_table: count table memory with a registered read, saturating add
// and write-back unit
// depends on wcc_pkg
module wcc_count_table #(
    parameter int DEPTH       = 4096,
    parameter int AW          = 12,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  wcc_pkg::tbl_op_t       op,
    input  logic [AW-1:0]          addr_a,
    input  logic [AW-1:0]          addr_b,
    output logic [COUNT_WIDTH-1:0] rd_data_a,
    output logic                   sat_hit
);

    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] mem [DEPTH];

    logic [COUNT_WIDTH-1:0] rd_a_reg;
    logic [COUNT_WIDTH-1:0] rd_b_reg;
    logic [AW-1:0]          wr_addr_reg;
    logic                   upd_reg;

    logic [COUNT_WIDTH:0]   sum_ext;
    logic                   sum_sat;
    logic [COUNT_WIDTH-1:0] sum_val;

    // saturating add of the two registered entries
    always_comb begin
        sum_ext = {1'b0, rd_a_reg} + {1'b0, rd_b_reg};
        sum_sat = (sum_ext >= {1'b0, CMAX});
        sum_val = sum_sat ? CMAX : sum_ext[COUNT_WIDTH-1:0];
    end

    assign sat_hit   = upd_reg & sum_sat;
    assign rd_data_a = rd_a_reg;

    // read ports and write port
    always_ff @(posedge aclk) begin
        if (op.rd || op.upd) begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
        end
        wr_addr_reg <= addr_a;
        if (op.clr) begin
            mem[addr_a] <= {{(COUNT_WIDTH-1){1'b0}}, op.clr_one};
        end else if (upd_reg) begin
            mem[wr_addr_reg] <= sum_val;
        end
    end

    // update in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upd_reg <= 1'b0;
        end else begin
            upd_reg <= op.upd;
        end
    end

endmodule

@@ sv/weight_combination_counter.sv @@
// weight_combination_counter: top level, sequencer around the count table
// depends on wcc_pkg and wcc_count_table
//
// Counts the ways a target mass T (s_tdata) can be made from the weights 100,
// 200, 300, 500, 1000, 1200, 1400, 1500, 2000 and 3000, each used at most once
// (unlimited_mode 0) or any number of times (unlimited_mode 1, written over the
// cfg port while the block is idle). One transaction in gives one out: m_tdata
// carries the count, saturated at 2^COUNT_WIDTH-1 (low 32 bits), m_tuser[0] is
// set if any addition saturated and m_tuser[1] if T exceeds MAX_AMOUNT (count
// then zero). The count table has one read-modify-write port pair, so a query
// walks the table one entry at a time: it clears entries 0..T, then for every
// weight w not above T sweeps entries w..T (down from T in mode 0, up from w in
// mode 1), with weight-selection steps between the sweeps and steps for the
// accept, final read and output load. An oversized target skips the table and
// goes straight to the output load. s_tready is low while a query is in
// progress; a finished result waits in the output register.
module weight_combination_counter #(
    parameter int MAX_AMOUNT  = 4095,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] target_amount
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] combination_count
    output logic [1:0]  m_tuser,   // [0] count_saturated, [1] target_too_large
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // unlimited_mode
);

    localparam int DEPTH = MAX_AMOUNT + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int EXT_W = (COUNT_WIDTH > wcc_pkg::OUT_COUNT_W) ? COUNT_WIDTH
                                                                : wcc_pkg::OUT_COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_NEXTW,
        ST_SWEEP,
        ST_READ,
        ST_FIN
    } state_t;

    state_t                            state_reg;
    logic                              mode_reg;
    logic [AW-1:0]                     target_reg;
    logic [AW-1:0]                     j_reg;
    logic [wcc_pkg::WIDX_W-1:0]        widx_reg;
    logic                              sat_reg;
    logic                              toobig_reg;
    logic                              m_tvalid_reg;
    logic [wcc_pkg::OUT_COUNT_W-1:0]   count_out_reg;
    logic                              sat_out_reg;
    logic                              toobig_out_reg;

    logic [wcc_pkg::WEIGHT_W-1:0]      weight_cur;
    logic [AW-1:0]                     weight_addr;
    logic [AW-1:0]                     sweep_end;
    wcc_pkg::tbl_op_t                  tbl_op;
    logic [AW-1:0]                     addr_a;
    logic [AW-1:0]                     addr_b;
    logic [COUNT_WIDTH-1:0]            rd_data_a;
    logic                              sat_hit;
    logic [EXT_W-1:0]                  count_ext;

    // current weight and sweep bounds
    always_comb begin
        weight_cur  = wcc_pkg::weight_of(widx_reg);
        weight_addr = AW'(weight_cur);
        sweep_end   = mode_reg ? target_reg : weight_addr;
        count_ext   = EXT_W'(rd_data_a);
    end

    // table operation for this cycle
    always_comb begin
        tbl_op.clr     = (state_reg == ST_CLEAR);
        tbl_op.clr_one = (j_reg == '0);
        tbl_op.upd     = (state_reg == ST_SWEEP);
        tbl_op.rd      = (state_reg == ST_READ);
        addr_a         = (state_reg == ST_READ) ? target_reg : j_reg;
        addr_b         = j_reg - weight_addr;
    end

    wcc_count_table #(
        .DEPTH       (DEPTH),
        .AW          (AW),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (tbl_op),
        .addr_a    (addr_a),
        .addr_b    (addr_b),
        .rd_data_a (rd_data_a),
        .sat_hit   (sat_hit)
    );

    // sequencer, config register and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // a result taken while the next one loads is replaced in ST_FIN
            if (m_tvalid_reg && m_tready && (state_reg != ST_FIN)) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            if (sat_hit) begin
                sat_reg <= 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tdata > wcc_pkg::TARGET_W'(MAX_AMOUNT)) begin
                            toobig_reg <= 1'b1;
                            state_reg  <= ST_FIN;
                        end else begin
                            toobig_reg <= 1'b0;
                            target_reg <= AW'(s_tdata);
                            j_reg      <= '0;
                            sat_reg    <= 1'b0;
                            state_reg  <= ST_CLEAR;
                        end
                    end
                end
                ST_CLEAR: begin
                    if (j_reg == target_reg) begin
                        widx_reg  <= '0;
                        state_reg <= ST_NEXTW;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_NEXTW: begin
                    if (widx_reg == wcc_pkg::WIDX_W'(wcc_pkg::NUM_WEIGHTS)) begin
                        state_reg <= ST_READ;
                    end else if (weight_cur > wcc_pkg::WEIGHT_W'(target_reg)) begin
                        widx_reg <= widx_reg + 1'b1;
                    end else begin
                        j_reg     <= mode_reg ? weight_addr : target_reg;
                        state_reg <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    if (j_reg == sweep_end) begin
                        widx_reg  <= widx_reg + 1'b1;
                        state_reg <= ST_NEXTW;
                    end else if (mode_reg) begin
                        j_reg <= j_reg + 1'b1;
                    end else begin
                        j_reg <= j_reg - 1'b1;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg   <= 1'b1;
                        count_out_reg  <= toobig_reg ? '0 : count_ext[wcc_pkg::OUT_COUNT_W-1:0];
                        sat_out_reg    <= !toobig_reg && sat_reg;
                        toobig_out_reg <= toobig_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = count_out_reg;
    assign m_tuser  = {toobig_out_reg, sat_out_reg};

endmodule

@@ sv/wcc_checker.sv @@
// wcc_checker: port-level assertions for the weight combination counter
// depends on weight_combination_counter (bound to it below)
module wcc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        cfg_ready
);

    // an oversized target reports a zero count and no saturation
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == 32'd0 && !m_tuser[0]))
        else $error("oversized target result not cleared");

    // the block is busy in the cycle after taking a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");

    // a result is loaded only at the end of a query, never from idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised while idle");

    // config is only taken while no query is running
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready |-> s_tready)
        else $error("config ready during a query");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind weight_combination_counter wcc_checker u_wcc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_ready (cfg_ready)
);
